>>> design/scp_pkg.sv
// Package of the serial port compander: transaction payload types, register
// indexes, companding mode codes and the configuration bundle.
// No dependencies; the configuration registers, conversion logic and top level import it.
package scp_pkg;

  localparam int unsigned SampleWidth  = 32;
  localparam int unsigned WordBitsW    = 6;
  localparam int unsigned ModeW        = 2;
  localparam int unsigned CfgIndexW    = 2;
  localparam logic [WordBitsW-1:0] CompandWordBits = WordBitsW'(8);

  typedef enum logic [ModeW-1:0] {
    MODE_NONE    = 2'd0,
    MODE_REVERSE = 2'd1,
    MODE_MULAW   = 2'd2,
    MODE_ALAW    = 2'd3
  } mode_e;

  typedef enum logic {
    CMD_COMPRESS = 1'b0,
    CMD_EXPAND   = 1'b1
  } cmd_e;

  typedef enum logic [CfgIndexW-1:0] {
    REG_TX_MODE      = 2'd0,
    REG_RX_MODE      = 2'd1,
    REG_TX_WORD_BITS = 2'd2,
    REG_RX_WORD_BITS = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic                   cmd;
    logic [SampleWidth-1:0] sample_in;
  } in_item_t;

  typedef struct packed {
    logic [SampleWidth-1:0] sample_out;
  } out_item_t;

  typedef struct packed {
    logic [CfgIndexW-1:0] index;
    logic [WordBitsW-1:0] data;
  } cfg_write_t;

  typedef struct packed {
    mode_e                tx_mode;
    mode_e                rx_mode;
    logic [WordBitsW-1:0] tx_word_bits;
    logic [WordBitsW-1:0] rx_word_bits;
  } cfg_t;

endpackage

>>> design/scp_stream_if.sv
// Valid/ready channel of the serial port compander, with a payload type
// chosen per instance. Used for the sample, result and configuration channels.
// Depends on nothing; payload types come from scp_pkg at the instance.
interface scp_stream_if #(
  parameter type payload_t = logic
);

  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);

endinterface

>>> design/scp_cfg_regs.sv
// Configuration registers of the serial port compander: modes and word
// lengths of both directions, written through the configuration channel.
// Depends on scp_pkg and scp_stream_if.
module scp_cfg_regs (
  input  logic          clk_i,
  input  logic          rst_ni,
  scp_stream_if.sink    cfg_i,
  output scp_pkg::cfg_t cfg_o
);
  import scp_pkg::*;

  cfg_t       cfg_q;
  cfg_t       cfg_d;
  cfg_write_t wr;

  assign wr          = cfg_i.payload;
  assign cfg_i.ready = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_i.valid) begin
      case (cfg_reg_e'(wr.index))
        REG_TX_MODE:      cfg_d.tx_mode      = mode_e'(wr.data[ModeW-1:0]);
        REG_RX_MODE:      cfg_d.rx_mode      = mode_e'(wr.data[ModeW-1:0]);
        REG_TX_WORD_BITS: cfg_d.tx_word_bits = wr.data;
        REG_RX_WORD_BITS: cfg_d.rx_word_bits = wr.data;
        default:          cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{tx_mode: MODE_NONE, rx_mode: MODE_NONE,
                 tx_word_bits: '0, rx_word_bits: '0};
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

>>> design/scp_convert.sv
// Conversion logic of the serial port compander: bit reversal, mu-law and
// A-law compression and expansion, and passthrough, for one transaction.
// Depends on scp_pkg.
module scp_convert (
  input  scp_pkg::cfg_t      cfg_i,
  input  scp_pkg::in_item_t  item_i,
  output scp_pkg::out_item_t item_o
);
  import scp_pkg::*;

  function automatic logic [7:0] rev8(input logic [7:0] v);
    logic [7:0] r;
    for (int k = 0; k < 8; k++) begin
      r[k] = v[7-k];
    end
    return r;
  endfunction

  // Magnitude of a signed 16-bit word, the most negative value saturated, as bits 14:3.
  function automatic logic [11:0] mag12(input logic [15:0] w);
    logic [15:0] m;
    if (w[15]) begin
      m = (w == 16'h8000) ? 16'h7fff : 16'(-w);
    end else begin
      m = w;
    end
    return m[14:3];
  endfunction

  function automatic logic [2:0] chord_of(input logic [11:0] m, input logic [12:0] base);
    logic [2:0] c;
    c = '0;
    for (int k = 0; k < 7; k++) begin
      if ({1'b0, m} >= (base << k)) begin
        c = 3'(k + 1);
      end
    end
    return c;
  endfunction

  function automatic logic [31:0] apply_sign(input logic [12:0] mag, input logic neg);
    return neg ? 32'(-{19'b0, mag}) : {19'b0, mag};
  endfunction

  logic [31:0] s;
  logic [11:0] mag;
  logic [2:0]  mu_chord;
  logic [2:0]  a_chord;
  logic [11:0] mu_shifted;
  logic [11:0] a_shifted;
  logic [7:0]  mu_code;
  logic [7:0]  a_code;
  logic [2:0]  seg;
  logic [5:0]  base;
  logic [12:0] mu_mag;
  logic [12:0] a_mag;
  logic [31:0] result;

  assign s          = item_i.sample_in;
  assign mag        = mag12(s[15:0]);
  assign mu_chord   = chord_of(mag, 13'h040);
  assign a_chord    = chord_of(mag, 13'h020);
  assign mu_shifted = mag >> ({1'b0, mu_chord} + 4'd1);
  assign a_shifted  = mag >> ((a_chord == 3'd0) ? 3'd1 : a_chord);
  assign mu_code    = {~s[15], mu_chord, mu_shifted[3:0]};
  assign a_code     = {s[15], a_chord, a_shifted[3:0]};

  assign seg    = s[6:4];
  assign base   = {1'b1, s[3:0], 1'b1};
  assign mu_mag = 13'(base) << seg;
  assign a_mag  = (seg == 3'd0) ? {8'b0, s[3:0], 1'b1} : (13'(base) << (seg - 3'd1));

  always_comb begin
    result = s;
    if (item_i.cmd == CMD_EXPAND) begin
      if (cfg_i.rx_word_bits == CompandWordBits) begin
        case (cfg_i.rx_mode)
          MODE_NONE:    result = s;
          MODE_REVERSE: result = {24'b0, rev8(s[7:0])};
          MODE_MULAW:   result = apply_sign(mu_mag, ~s[7]);
          MODE_ALAW:    result = apply_sign(a_mag, s[7]);
          default:      result = s;
        endcase
      end
    end else begin
      if (cfg_i.tx_word_bits == CompandWordBits) begin
        case (cfg_i.tx_mode)
          MODE_NONE:    result = s;
          MODE_REVERSE: result = {24'b0, rev8(s[7:0])};
          MODE_MULAW:   result = {24'b0, mu_code};
          MODE_ALAW:    result = {24'b0, a_code};
          default:      result = s;
        endcase
      end
    end
  end

  assign item_o.sample_out = result;

endmodule

>>> design/serial_port_compander_core.sv
// Top level of the serial port compander: input register, conversion logic
// and result register, with the configuration registers beside them.
// Depends on scp_pkg, scp_stream_if, scp_cfg_regs and scp_convert.
//
// The block converts one audio word per transaction on in_i. With cmd low it
// compresses a transmit word, with cmd high it expands a received byte, both
// according to the direction's mode and word length held in the
// configuration registers. Those are written through cfg_i, which is always
// ready, and should only be changed while no transaction is in flight.
// Every input transaction yields exactly one result transaction on out_o.
// An accepted transaction is loaded into the input register and, once the
// result register is free, passes through the conversion logic into the
// result register, which presents it on out_o. Throughput is one
// transaction per cycle while out_o does not stall, set by the single
// conversion stage between the registers.
// When the receiver stalls, the result register holds its word, the input
// register still takes one more word, and in_i.ready then falls until out_o
// moves again. Reset empties both registers and clears all configuration
// registers to zero, which selects passthrough in both directions.
module serial_port_compander_core (
  input  logic         clk_i,
  input  logic         rst_ni,
  scp_stream_if.sink   in_i,
  scp_stream_if.source out_o,
  scp_stream_if.sink   cfg_i
);
  import scp_pkg::*;

  cfg_t      cfg;
  in_item_t  s1_q;
  logic      s1_valid_q;
  logic      s1_valid_d;
  out_item_t conv;
  out_item_t out_q;
  logic      out_valid_q;
  logic      out_valid_d;
  logic      s1_ready;
  logic      s2_ready;

  scp_cfg_regs u_cfg_regs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  scp_convert u_convert (
    .cfg_i  (cfg),
    .item_i (s1_q),
    .item_o (conv)
  );

  assign s2_ready   = !out_valid_q || out_o.ready;
  assign s1_ready   = !s1_valid_q || s2_ready;
  assign in_i.ready = s1_ready;

  assign s1_valid_d  = s1_ready ? in_i.valid : s1_valid_q;
  assign out_valid_d = s2_ready ? s1_valid_q : out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && s1_ready) begin
      s1_q <= in_i.payload;
    end
    if (s1_valid_q && s2_ready) begin
      out_q <= conv;
    end
  end

  assign out_o.valid   = out_valid_q;
  assign out_o.payload = out_q;

  a_accept_fills_s1 : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready |=> s1_valid_q)
    else $error("accepted transaction not held in the input register");

  a_s1_moves_on : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && s2_ready |=> out_valid_q)
    else $error("transaction lost between input and result register");

  a_full_blocks_input : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && out_valid_q && !out_o.ready |-> !in_i.ready)
    else $error("input accepted while both registers are full and stalled");

  a_rx_passthrough : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && s2_ready && s1_q.cmd == CMD_EXPAND
      && cfg.rx_word_bits != CompandWordBits
    |=> out_q.sample_out == $past(s1_q.sample_in))
    else $error("received word not passed through unchanged");

endmodule
